FILE: hdl/mxt_pkg.sv
`default_nettype none
package mxt_pkg;

	localparam int KEY_BITS  = 31;
	localparam int NODE_POOL = 4096;
	localparam int NODE_AW   = $clog2(NODE_POOL);
	localparam int AVAIL_W   = NODE_AW + 1;
	localparam int LVL_W     = $clog2(KEY_BITS);
	localparam int CNT_W     = 32;
	localparam int ACT_W     = 2;
	localparam int ST_W      = 2;
	localparam int IN_W      = ((ACT_W + KEY_BITS + 7) / 8) * 8;
	localparam int OUT_W     = ((KEY_BITS + ST_W + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_EXEC,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_CHECK,
		PH_MAIN,
		PH_CHAIN
	} phase_t;

	typedef struct packed {
		logic [1:0]         vld;
		logic [NODE_AW-1:0] lnk1;
		logic [NODE_AW-1:0] lnk0;
		logic [CNT_W-1:0]   cnt;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef struct packed {
		logic               pop;
		logic               push;
		logic               clear;
		logic [NODE_AW-1:0] node;
	} alloc_ctl_t;

	function automatic logic [NODE_AW-1:0] node_link(input node_t n, input logic b);
		node_link = b ? n.lnk1 : n.lnk0;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/mxt_ram.sv
`default_nettype none
module mxt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/mxt_alloc.sv
`default_nettype none
module mxt_alloc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mxt_pkg::alloc_ctl_t           ctl,
	output logic [mxt_pkg::NODE_AW-1:0]   node,
	output logic [mxt_pkg::AVAIL_W-1:0]   avail
);

	// freed nodes on a stack, never-used nodes from a fill mark
	logic [mxt_pkg::AVAIL_W-1:0] top_q;
	logic [mxt_pkg::AVAIL_W-1:0] fresh_q;
	logic [mxt_pkg::NODE_AW-1:0] rd_data;
	logic [mxt_pkg::NODE_AW-1:0] rd_addr;

	assign rd_addr = top_q[mxt_pkg::NODE_AW-1:0] - 1'b1;

	mxt_ram #(
		.WIDTH(mxt_pkg::NODE_AW),
		.DEPTH(mxt_pkg::NODE_POOL)
	) u_stack (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (top_q[mxt_pkg::NODE_AW-1:0]),
		.wdata (ctl.node),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			fresh_q <= mxt_pkg::AVAIL_W'(1);
		end else if (ctl.clear) begin
			top_q   <= '0;
			fresh_q <= mxt_pkg::AVAIL_W'(1);
		end else if (ctl.push) begin
			top_q <= top_q + 1'b1;
		end else if (ctl.pop) begin
			if (top_q != '0) begin
				top_q <= top_q - 1'b1;
			end else begin
				fresh_q <= fresh_q + 1'b1;
			end
		end
	end

	assign node  = (top_q != '0) ? rd_data : fresh_q[mxt_pkg::NODE_AW-1:0];
	assign avail = top_q + (mxt_pkg::AVAIL_W'(mxt_pkg::NODE_POOL) - fresh_q);

endmodule
`default_nettype wire

FILE: hdl/max_xor_bit_trie.sv
// channel  dir  signals                          contents (low bit up)
// s_axis   in   s_axis_tvalid/tready/tdata[39:0] action[1:0], operand_value[32:2]
// m_axis   out  m_axis_tvalid/tready/tdata[39:0] best_xor[30:0], status[32:31]
//
// One item at a time. Each trie level is a read of the registered-read node RAM, then
// the node step (with a write on an update walk). Insert/delete: check walk plus update walk;
// query: one walk; trivial cases go straight to the result.
// After reset the INIT state writes an empty root before the first item is taken.
// A result is held on m_axis until taken; no new item is accepted meanwhile.
`default_nettype none
module max_xor_bit_trie (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [mxt_pkg::IN_W-1:0]  s_axis_tdata,  // action, operand_value
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [mxt_pkg::OUT_W-1:0] m_axis_tdata   // best_xor, status
);

	mxt_pkg::state_t  state_q, state_n;
	mxt_pkg::phase_t  phase_q, phase_n;
	mxt_pkg::action_t op_q, op_n;
	logic [mxt_pkg::KEY_BITS-1:0] key_q, key_n;
	logic [mxt_pkg::KEY_BITS-1:0] acc_q, acc_n;
	logic [mxt_pkg::KEY_BITS-1:0] best_q, best_n;
	logic [mxt_pkg::LVL_W-1:0]    lvl_q, lvl_n;
	logic [mxt_pkg::NODE_AW-1:0]  node_q, node_n;
	logic [mxt_pkg::NODE_AW-1:0]  par_addr_q, par_addr_n;
	mxt_pkg::node_t               par_q, par_n;
	logic                         leaf_q, leaf_n;
	logic                         root_q, root_n;
	logic                         fresh_q, fresh_n;
	logic [mxt_pkg::CNT_W-1:0]    root_cnt_q, root_cnt_n;
	mxt_pkg::status_t             st_q, st_n;

	logic [mxt_pkg::NODE_W-1:0]   rd_node;
	logic                         node_we;
	logic [mxt_pkg::NODE_AW-1:0]  node_waddr;
	mxt_pkg::node_t               node_wdata;
	mxt_pkg::alloc_ctl_t          actl;
	logic [mxt_pkg::NODE_AW-1:0]  alloc_node;
	logic [mxt_pkg::AVAIL_W-1:0]  avail;

	mxt_ram #(
		.WIDTH(mxt_pkg::NODE_W),
		.DEPTH(mxt_pkg::NODE_POOL)
	) u_nodes (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_q),
		.rdata (rd_node)
	);

	mxt_alloc u_alloc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (actl),
		.node   (alloc_node),
		.avail  (avail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mxt_pkg::S_INIT;
			phase_q    <= mxt_pkg::PH_CHECK;
			op_q       <= mxt_pkg::ACT_NOP;
			root_cnt_q <= '0;
			leaf_q     <= 1'b0;
			root_q     <= 1'b0;
			fresh_q    <= 1'b0;
		end else begin
			state_q    <= state_n;
			phase_q    <= phase_n;
			op_q       <= op_n;
			root_cnt_q <= root_cnt_n;
			leaf_q     <= leaf_n;
			root_q     <= root_n;
			fresh_q    <= fresh_n;
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= key_n;
		acc_q      <= acc_n;
		best_q     <= best_n;
		lvl_q      <= lvl_n;
		node_q     <= node_n;
		par_addr_q <= par_addr_n;
		par_q      <= par_n;
		st_q       <= st_n;
	end

	always_comb begin
		mxt_pkg::node_t d;
		mxt_pkg::node_t dn;
		mxt_pkg::node_t pw;
		logic kb;
		logic kb_nx;
		logic [mxt_pkg::LVL_W-1:0] lvl_m1;
		logic [mxt_pkg::LVL_W:0] need;

		state_n    = state_q;
		phase_n    = phase_q;
		op_n       = op_q;
		key_n      = key_q;
		acc_n      = acc_q;
		best_n     = best_q;
		lvl_n      = lvl_q;
		node_n     = node_q;
		par_addr_n = par_addr_q;
		par_n      = par_q;
		leaf_n     = leaf_q;
		root_n     = root_q;
		fresh_n    = fresh_q;
		root_cnt_n = root_cnt_q;
		st_n       = st_q;
		node_we    = 1'b0;
		node_waddr = node_q;
		node_wdata = '0;
		actl       = '0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;

		d      = rd_node;
		dn     = d;
		pw     = par_q;
		kb     = key_q[lvl_q];
		lvl_m1 = lvl_q - 1'b1;
		kb_nx  = key_q[lvl_m1];
		need   = {1'b0, lvl_q} + 1'b1;

		case (state_q)
			mxt_pkg::S_INIT: begin
				node_we    = 1'b1;
				node_waddr = '0;
				state_n    = mxt_pkg::S_IDLE;
			end
			mxt_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					op_n    = mxt_pkg::action_t'(s_axis_tdata[mxt_pkg::ACT_W-1:0]);
					key_n   = s_axis_tdata[mxt_pkg::ACT_W +: mxt_pkg::KEY_BITS];
					lvl_n   = mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
					node_n  = '0;
					root_n  = 1'b1;
					fresh_n = 1'b0;
					leaf_n  = 1'b0;
					acc_n   = '0;
					best_n  = '0;
					st_n    = mxt_pkg::ST_OK;
					phase_n = mxt_pkg::PH_CHECK;
					state_n = mxt_pkg::S_RD;
					case (mxt_pkg::action_t'(s_axis_tdata[mxt_pkg::ACT_W-1:0]))
						mxt_pkg::ACT_INSERT: ;
						mxt_pkg::ACT_DELETE: begin
							if (root_cnt_q == '0) begin
								st_n    = mxt_pkg::ST_ABSENT;
								state_n = mxt_pkg::S_DONE;
							end
						end
						mxt_pkg::ACT_QUERY: begin
							phase_n = mxt_pkg::PH_MAIN;
							if (root_cnt_q == '0) begin
								st_n    = mxt_pkg::ST_EMPTY;
								state_n = mxt_pkg::S_DONE;
							end
						end
						default: state_n = mxt_pkg::S_DONE;
					endcase
				end
			end
			mxt_pkg::S_RD: state_n = mxt_pkg::S_EXEC;
			mxt_pkg::S_EXEC: begin
				state_n = mxt_pkg::S_RD;
				case (phase_q)
					mxt_pkg::PH_CHECK: begin
						if (!d.vld[kb] || lvl_q == '0) begin
							if (!d.vld[kb] && op_q == mxt_pkg::ACT_DELETE) begin
								st_n    = mxt_pkg::ST_ABSENT;
								state_n = mxt_pkg::S_DONE;
							end else begin
								if (d.vld[kb]) begin
									need = '0;
								end
								node_n  = '0;
								lvl_n   = mxt_pkg::LVL_W'(mxt_pkg::KEY_BITS - 1);
								root_n  = 1'b1;
								phase_n = mxt_pkg::PH_MAIN;
								if (op_q == mxt_pkg::ACT_INSERT) begin
									if (mxt_pkg::AVAIL_W'(need) > avail || (&root_cnt_q)) begin
										st_n    = mxt_pkg::ST_FULL;
										state_n = mxt_pkg::S_DONE;
									end else begin
										root_cnt_n = root_cnt_q + 1'b1;
									end
								end else if (root_cnt_q == mxt_pkg::CNT_W'(1)) begin
									// last key gone: empty root, all nodes free
									node_we    = 1'b1;
									node_waddr = '0;
									actl.clear = 1'b1;
									root_cnt_n = '0;
									state_n    = mxt_pkg::S_DONE;
								end else begin
									root_cnt_n = root_cnt_q - 1'b1;
								end
							end
						end else begin
							node_n = mxt_pkg::node_link(d, kb);
							lvl_n  = lvl_m1;
						end
					end
					mxt_pkg::PH_MAIN: begin
						case (op_q)
							mxt_pkg::ACT_INSERT: begin
								if (fresh_q) begin
									d = '0;
								end
								dn     = d;
								dn.cnt = d.cnt + 1'b1;
								node_we    = 1'b1;
								node_waddr = node_q;
								if (leaf_q) begin
									state_n = mxt_pkg::S_DONE;
								end else begin
									if (d.vld[kb]) begin
										node_n  = mxt_pkg::node_link(d, kb);
										fresh_n = 1'b0;
									end else begin
										actl.pop = 1'b1;
										node_n   = alloc_node;
										fresh_n  = 1'b1;
										dn.vld[kb] = 1'b1;
										if (kb) begin
											dn.lnk1 = alloc_node;
										end else begin
											dn.lnk0 = alloc_node;
										end
									end
									if (lvl_q == '0) begin
										leaf_n = 1'b1;
									end else begin
										lvl_n = lvl_m1;
									end
								end
								node_wdata = dn;
							end
							mxt_pkg::ACT_DELETE: begin
								if (root_q) begin
									par_n      = d;
									par_addr_n = node_q;
									node_n     = mxt_pkg::node_link(d, kb);
									root_n     = 1'b0;
								end else if (d.cnt <= mxt_pkg::CNT_W'(1)) begin
									pw.vld[kb] = 1'b0;
									node_we    = 1'b1;
									node_waddr = par_addr_q;
									node_wdata = pw;
									actl.push  = 1'b1;
									actl.node  = node_q;
									if (lvl_q != '0 && d.vld[kb_nx]) begin
										node_n  = mxt_pkg::node_link(d, kb_nx);
										lvl_n   = lvl_m1;
										phase_n = mxt_pkg::PH_CHAIN;
									end else begin
										state_n = mxt_pkg::S_DONE;
									end
								end else begin
									dn.cnt     = d.cnt - 1'b1;
									node_we    = 1'b1;
									node_waddr = node_q;
									node_wdata = dn;
									if (lvl_q == '0) begin
										state_n = mxt_pkg::S_DONE;
									end else begin
										par_n      = dn;
										par_addr_n = node_q;
										node_n     = mxt_pkg::node_link(dn, kb_nx);
										lvl_n      = lvl_m1;
									end
								end
							end
							default: begin
								if (d.vld[~kb]) begin
									node_n        = mxt_pkg::node_link(d, ~kb);
									acc_n[lvl_q]  = 1'b1;
								end else if (d.vld[kb]) begin
									node_n = mxt_pkg::node_link(d, kb);
								end else begin
									state_n = mxt_pkg::S_DONE;
								end
								if (lvl_q == '0) begin
									state_n = mxt_pkg::S_DONE;
								end else begin
									lvl_n = lvl_m1;
								end
								best_n = d.vld[~kb] ? (acc_q | (mxt_pkg::KEY_BITS'(1) << lvl_q))
									: acc_q;
							end
						endcase
					end
					mxt_pkg::PH_CHAIN: begin
						actl.push = 1'b1;
						actl.node = node_q;
						if (lvl_q != '0 && d.vld[kb_nx]) begin
							node_n = mxt_pkg::node_link(d, kb_nx);
							lvl_n  = lvl_m1;
						end else begin
							state_n = mxt_pkg::S_DONE;
						end
					end
					default: state_n = mxt_pkg::S_DONE;
				endcase
			end
			mxt_pkg::S_DONE: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_n = mxt_pkg::S_IDLE;
				end
			end
			default: state_n = mxt_pkg::S_IDLE;
		endcase
	end

	assign m_axis_tdata = mxt_pkg::OUT_W'({st_q, best_q});

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken during a walk");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		avail <= mxt_pkg::AVAIL_W'(mxt_pkg::NODE_POOL - 1))
		else $error("free node count beyond pool");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_q != mxt_pkg::ST_OK |-> best_q == '0)
		else $error("flagged result with non-zero value");

endmodule
`default_nettype wire

FILE: tb/max_xor_bit_trie_tb.sv
`timescale 1ns / 100ps
module max_xor_bit_trie_tb;

	localparam int FREE_NODES = mxt_pkg::NODE_POOL - 1;

	typedef struct {
		logic [mxt_pkg::KEY_BITS-1:0] best;
		mxt_pkg::status_t             st;
	} answer_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [mxt_pkg::IN_W-1:0]      s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [mxt_pkg::OUT_W-1:0]     m_axis_tdata;

	// trie shadow: stored keys with multiplicity, and use count per prefix (one per node)
	int unsigned                   key_mult[logic [mxt_pkg::KEY_BITS-1:0]];
	int unsigned                   prefix_use[longint];
	int                            nodes_used;
	longint unsigned               keys_stored;
	logic [mxt_pkg::KEY_BITS-1:0]  key_list[$];

	answer_t                       answers_due[$];
	int                            errs;
	int                            burst_left;

	max_xor_bit_trie uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("max_xor_bit_trie_tb: done, errors");
		$finish;
	end

	function automatic logic [mxt_pkg::KEY_BITS-1:0] rand_key();
		return mxt_pkg::KEY_BITS'($urandom());
	endfunction

	function automatic longint prefix_id(int len, logic [mxt_pkg::KEY_BITS-1:0] k);
		prefix_id = (longint'(len) << 32) | longint'(k >> (mxt_pkg::KEY_BITS - len));
	endfunction

	function automatic answer_t trie_answer(mxt_pkg::action_t act,
			logic [mxt_pkg::KEY_BITS-1:0] v);
		answer_t r;
		int need;
		longint id;
		logic [mxt_pkg::KEY_BITS-1:0] p;
		logic want;
		r.best = '0;
		r.st = mxt_pkg::ST_OK;
		need = 0;
		case (act)
		mxt_pkg::ACT_INSERT: begin
			for (int len = 1; len <= mxt_pkg::KEY_BITS; len++) begin
				if (need == 0 && !prefix_use.exists(prefix_id(len, v)))
					need = mxt_pkg::KEY_BITS + 1 - len;
			end
			if (need > FREE_NODES - nodes_used || keys_stored == 64'hFFFF_FFFF) begin
				r.st = mxt_pkg::ST_FULL;
			end else begin
				for (int len = 1; len <= mxt_pkg::KEY_BITS; len++) begin
					id = prefix_id(len, v);
					if (prefix_use.exists(id)) begin
						prefix_use[id]++;
					end else begin
						prefix_use[id] = 1;
						nodes_used++;
					end
				end
				if (key_mult.exists(v)) key_mult[v]++;
				else key_mult[v] = 1;
				keys_stored++;
			end
		end
		mxt_pkg::ACT_DELETE: begin
			if (!key_mult.exists(v)) begin
				r.st = mxt_pkg::ST_ABSENT;
			end else begin
				for (int len = 1; len <= mxt_pkg::KEY_BITS; len++) begin
					id = prefix_id(len, v);
					prefix_use[id]--;
					if (prefix_use[id] == 0) begin
						prefix_use.delete(id);
						nodes_used--;
					end
				end
				key_mult[v]--;
				if (key_mult[v] == 0) key_mult.delete(v);
				keys_stored--;
			end
		end
		mxt_pkg::ACT_QUERY: begin
			if (keys_stored == 0) begin
				r.st = mxt_pkg::ST_EMPTY;
			end else begin
				p = '0;
				for (int i = mxt_pkg::KEY_BITS - 1; i >= 0; i--) begin
					want = ~v[i];
					if (prefix_use.exists((longint'(mxt_pkg::KEY_BITS - i) << 32)
							| longint'({p[mxt_pkg::KEY_BITS-2:0], want}))) begin
						p = {p[mxt_pkg::KEY_BITS-2:0], want};
						r.best[i] = 1'b1;
					end else begin
						p = {p[mxt_pkg::KEY_BITS-2:0], v[i]};
					end
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// one item; the sender sends in bursts with idle gaps between them
	task automatic send_item(mxt_pkg::action_t act, logic [mxt_pkg::KEY_BITS-1:0] v);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(mxt_pkg::IN_W - mxt_pkg::ACT_W - mxt_pkg::KEY_BITS){1'b0}}, v, act};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		answers_due.insert(answers_due.size(), trie_answer(act, v));
		if (act == mxt_pkg::ACT_INSERT && answers_due[$].st == mxt_pkg::ST_OK)
			key_list.insert(key_list.size(), v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [mxt_pkg::KEY_BITS-1:0] pick_key();
		if (key_list.size() != 0 && $urandom_range(0, 3) != 0)
			return key_list[$urandom_range(0, key_list.size() - 1)];
		return rand_key();
	endfunction

	// receiver stall pattern
	initial begin
		int mode;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(50, 400)) begin
				@(posedge clk);
				case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				$error("unexpected item: tdata %h", m_axis_tdata);
				errs++;
			end else begin
				e = answers_due.pop_front();
				if (m_axis_tdata[mxt_pkg::KEY_BITS-1:0] !== e.best) begin
					$error("best_xor: expected %h, got %h", e.best,
						m_axis_tdata[mxt_pkg::KEY_BITS-1:0]);
					errs++;
				end
				if (m_axis_tdata[mxt_pkg::KEY_BITS+mxt_pkg::ST_W-1:mxt_pkg::KEY_BITS]
						!== e.st) begin
					$error("status: expected %0d, got %0d", e.st,
						m_axis_tdata[mxt_pkg::KEY_BITS+mxt_pkg::ST_W-1:mxt_pkg::KEY_BITS]);
					errs++;
				end
			end
		end
	end

	task automatic test_directed();
		send_item(mxt_pkg::ACT_QUERY, 31'h0);
		send_item(mxt_pkg::ACT_DELETE, 31'h0);
		send_item(mxt_pkg::ACT_NOP, 31'h7FFF_FFFF);
		send_item(mxt_pkg::ACT_INSERT, 31'h0);
		send_item(mxt_pkg::ACT_INSERT, 31'h7FFF_FFFF);
		send_item(mxt_pkg::ACT_QUERY, 31'h0);
		send_item(mxt_pkg::ACT_QUERY, 31'h7FFF_FFFF);
		send_item(mxt_pkg::ACT_INSERT, 31'h0);
		send_item(mxt_pkg::ACT_DELETE, 31'h0);
		send_item(mxt_pkg::ACT_QUERY, 31'h7FFF_FFFF);
		send_item(mxt_pkg::ACT_DELETE, 31'h0);
		send_item(mxt_pkg::ACT_DELETE, 31'h0);
		send_item(mxt_pkg::ACT_QUERY, 31'h5555_5555);
		send_item(mxt_pkg::ACT_INSERT, 31'h2AAA_AAAA);
		send_item(mxt_pkg::ACT_DELETE, 31'h2AAA_AAAB);
		send_item(mxt_pkg::ACT_QUERY, 31'h5555_5555);
		send_item(mxt_pkg::ACT_DELETE, 31'h2AAA_AAAA);
		send_item(mxt_pkg::ACT_DELETE, 31'h7FFF_FFFF);
		send_item(mxt_pkg::ACT_QUERY, 31'h1234_5678);
		send_item(mxt_pkg::ACT_NOP, 31'h0);
		send_item(mxt_pkg::ACT_INSERT, 31'h4000_0000);
		send_item(mxt_pkg::ACT_QUERY, 31'h4000_0000);
		send_item(mxt_pkg::ACT_DELETE, 31'h4000_0000);
		wait_drain();
	endtask

	task automatic test_random_mix(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 19);
			if (r < 8) send_item(mxt_pkg::ACT_INSERT,
				($urandom_range(0, 3) == 0) ? pick_key() : rand_key());
			else if (r < 13) send_item(mxt_pkg::ACT_DELETE, pick_key());
			else if (r < 19) send_item(mxt_pkg::ACT_QUERY, rand_key());
			else send_item(mxt_pkg::ACT_NOP, rand_key());
		end
	endtask

	// fill the node pool past its end, then empty the store again
	task automatic test_pool_full();
		int n;
		n = 0;
		while (n < 220) begin
			send_item(mxt_pkg::ACT_INSERT, rand_key());
			if ($urandom_range(0, 7) == 0) send_item(mxt_pkg::ACT_QUERY, rand_key());
			n++;
		end
		send_item(mxt_pkg::ACT_INSERT, pick_key());
		send_item(mxt_pkg::ACT_QUERY, 31'h0);
		wait_drain();
		while (key_list.size() != 0) begin
			n = $urandom_range(0, key_list.size() - 1);
			send_item(mxt_pkg::ACT_DELETE, key_list[n]);
			key_list.delete(n);
			if ($urandom_range(0, 15) == 0) send_item(mxt_pkg::ACT_QUERY, rand_key());
		end
		send_item(mxt_pkg::ACT_QUERY, rand_key());
	endtask

	initial begin
		errs = 0;
		burst_left = 0;
		nodes_used = 0;
		keys_stored = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(100);
		wait_drain();
		test_pool_full();
		test_random_mix(80);
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errs == 0)
			$display("max_xor_bit_trie_tb: done, clean");
		else
			$display("max_xor_bit_trie_tb: done, errors");
		$finish;
	end

endmodule
